### design/spiral_tile_order_generator_top_assert.svh
// assertion macros for the spiral tile order generator
`ifndef SPIRAL_TILE_ORDER_GENERATOR_TOP_ASSERT_SVH
`define SPIRAL_TILE_ORDER_GENERATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define STOG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stog assertion failed");

// antecedent implies consequent in the next cycle
`define STOG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stog assertion failed");

`endif

### design/stog_pkg.sv
// shared types and constants of the spiral tile order generator
`timescale 1ns / 1ps

package stog_pkg;

   localparam int DIM_W  = 14;             // image size and pixel offset
   localparam int TILE_W = 11;             // tile size
   localparam int CNT_W  = 14;             // tiles across or down
   localparam int REM_W  = 2 * CNT_W;      // tiles remaining
   localparam int CUR_W  = 16;             // signed spiral cursor and leg counters
   localparam int DIVD_W = DIM_W + 1;      // image size plus tile size minus one
   localparam int IDX_W  = 2;

   localparam int MAX_IMAGE_DIM_DEF = 16383;
   localparam int MAX_TILE_SIZE_DEF = 1024;

   localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(480);
   localparam logic [TILE_W-1:0] RST_TILE_SIZE    = TILE_W'(32);

   localparam logic [IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_TILE_SIZE    = 2'd2;

   typedef enum logic [1:0] {
      HEAD_RIGHT = 2'd0,
      HEAD_DOWN  = 2'd1,
      HEAD_LEFT  = 2'd2,
      HEAD_UP    = 2'd3
   } heading_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_INIT,
      ST_CALC,
      ST_EMIT,
      ST_WALK
   } stog_state_type;

   typedef struct packed {
      logic latch_cfg;    // latch configuration, divide width
      logic div_next;     // store tiles across, divide height
      logic store_y;      // store tiles down
      logic init_spiral;  // tile total and centre cursor
      logic calc_pos;     // pixel offsets of the cursor tile
      logic load_out;     // fill the result register
      logic step;         // one spiral step
   } stog_cmd_type;

   typedef struct packed {
      logic div_done;
      logic remaining_zero;
      logic remaining_one;
      logic next_on_grid;
      logic out_full;
   } stog_stat_type;

endpackage

### design/spiral_tile_order_generator_top.sv
// top level of the spiral tile order generator
// a word without restart passes through the offset multiply, then the result load; a restart
// first divides width and height by the tile size, then forms the tile total and centre
// a new request is taken only back in idle, after the word is loaded and the walk is done
// reset: synchronous, clears sequencer, divider and result valid; size registers return
// to 640 x 480 with 32 pixel tiles and no tile is served until a restart
`timescale 1ns / 1ps
`include "spiral_tile_order_generator_top_assert.svh"

module spiral_tile_order_generator_top #(
   parameter int MAX_IMAGE_DIM = stog_pkg::MAX_IMAGE_DIM_DEF,
   parameter int MAX_TILE_SIZE = stog_pkg::MAX_TILE_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [stog_pkg::IDX_W-1:0]  csr_index,
   input  logic [stog_pkg::DIM_W-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_tile_valid,
   output logic [stog_pkg::DIM_W-1:0]  rsp_tile_offset_x,
   output logic [stog_pkg::DIM_W-1:0]  rsp_tile_offset_y,
   output logic [stog_pkg::TILE_W-1:0] rsp_tile_width,
   output logic [stog_pkg::TILE_W-1:0] rsp_tile_height,
   output logic                        rsp_tile_last
);

   import stog_pkg::*;

   stog_cmd_type  cmd;
   stog_stat_type stat;

   stog_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   stog_dpath #(
      .MAX_IMAGE_DIM(MAX_IMAGE_DIM),
      .MAX_TILE_SIZE(MAX_TILE_SIZE)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_tile_valid    (rsp_tile_valid),
      .rsp_tile_offset_x (rsp_tile_offset_x),
      .rsp_tile_offset_y (rsp_tile_offset_y),
      .rsp_tile_width    (rsp_tile_width),
      .rsp_tile_height   (rsp_tile_height),
      .rsp_tile_last     (rsp_tile_last)
   );

   // an accepted request keeps the block busy in the next cycle
   `STOG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // with nothing left the word carries no tile
   `STOG_ASSERT_NEXT(a_null_word, clock, reset, cmd.load_out && stat.remaining_zero, rsp_valid && !rsp_tile_valid)
   // the final tile is flagged last
   `STOG_ASSERT_NEXT(a_last_word, clock, reset, cmd.load_out && stat.remaining_one, rsp_tile_valid && rsp_tile_last)
   // the result register is only filled when it can take a word
   `STOG_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.load_out, !(rsp_valid && rsp_stall))

endmodule

### design/stog_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module stog_div #(
   parameter int DIVD_W = 15,
   parameter int DSOR_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DSOR_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIVD_W + 1);

   logic [DSOR_W-1:0]   rem_ff, rem_in;
   logic [DIVD_W-1:0]   quo_ff, quo_in;
   logic [DSOR_W-1:0]   dsor_ff, dsor_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DSOR_W:0]     shifted;
   logic [DSOR_W+1:0]   diff;

   assign shifted = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsor_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsor_in = dsor_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsor_in = divisor;
         cnt_in  = CNT_BITS'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the trial difference when it does not borrow
         if (!diff[DSOR_W+1]) begin
            rem_in = diff[DSOR_W-1:0];
         end else begin
            rem_in = shifted[DSOR_W-1:0];
         end
         quo_in = {quo_ff[DIVD_W-2:0], ~diff[DSOR_W+1]};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/stog_ctrl.sv
// sequencer: request handshake, restart, tile emission and spiral walk
`timescale 1ns / 1ps

module stog_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_restart,
   output logic                   req_stall,
   input  stog_pkg::stog_stat_type stat,
   output stog_pkg::stog_cmd_type  cmd
);

   import stog_pkg::*;

   stog_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  cmd.latch_cfg = 1'b1;
                  state_in      = ST_DIV_X;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_DIV_X: begin
            if (stat.div_done) begin
               cmd.div_next = 1'b1;
               state_in     = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (stat.div_done) begin
               cmd.store_y = 1'b1;
               state_in    = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_spiral = 1'b1;
            state_in        = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc_pos = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.out_full) begin
               cmd.load_out = 1'b1;
               if (stat.remaining_zero || stat.remaining_one) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.next_on_grid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/stog_dpath.sv
// datapath: config registers, tile counts, spiral cursor and result register
`timescale 1ns / 1ps

module stog_dpath #(
   parameter int MAX_IMAGE_DIM = stog_pkg::MAX_IMAGE_DIM_DEF,
   parameter int MAX_TILE_SIZE = stog_pkg::MAX_TILE_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [stog_pkg::IDX_W-1:0]  csr_index,
   input  logic [stog_pkg::DIM_W-1:0]  csr_wdata,
   input  stog_pkg::stog_cmd_type      cmd,
   output stog_pkg::stog_stat_type     stat,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic                        rsp_tile_valid,
   output logic [stog_pkg::DIM_W-1:0]  rsp_tile_offset_x,
   output logic [stog_pkg::DIM_W-1:0]  rsp_tile_offset_y,
   output logic [stog_pkg::TILE_W-1:0] rsp_tile_width,
   output logic [stog_pkg::TILE_W-1:0] rsp_tile_height,
   output logic                        rsp_tile_last
);

   import stog_pkg::*;

   localparam int PX_W = DIM_W + TILE_W;

   logic [DIM_W-1:0]  cfg_w_ff, cfg_h_ff;
   logic [TILE_W-1:0] cfg_t_ff;

   logic [DIM_W-1:0]  lat_w_ff, lat_h_ff;
   logic [TILE_W-1:0] lat_t_ff;
   logic [CNT_W-1:0]  across_ff, down_ff;
   logic [REM_W-1:0]  remaining_ff;
   logic signed [CUR_W-1:0] cur_x_ff, cur_y_ff;
   heading_type       heading_ff;
   logic [CUR_W-1:0]  leg_left_ff, leg_len_ff;
   logic [DIM_W-1:0]  px_ff, py_ff;

   logic              out_valid_ff, out_tvalid_ff, out_last_ff;
   logic [DIM_W-1:0]  out_x_ff, out_y_ff;
   logic [TILE_W-1:0] out_w_ff, out_h_ff;

   logic [DIM_W-1:0]  clamp_w, clamp_h;
   logic [TILE_W-1:0] clamp_t;
   logic [DIVD_W-1:0] div_dividend;
   logic              div_start, div_done;
   logic [DIVD_W-1:0] div_quot;

   logic signed [CUR_W-1:0] nx, ny;
   heading_type       head_n;
   logic [CUR_W-1:0]  leg_left_n, leg_len_n, leg_dec;
   logic [PX_W-1:0]   prod_x, prod_y;
   logic [DIM_W-1:0]  lx, ly;
   logic [TILE_W-1:0] clip_w, clip_h;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= RST_IMAGE_WIDTH;
         cfg_h_ff <= RST_IMAGE_HEIGHT;
         cfg_t_ff <= RST_TILE_SIZE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_w_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_h_ff <= csr_wdata;
            CSR_TILE_SIZE:    cfg_t_ff <= csr_wdata[TILE_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate sizes as they are latched; a zero tile size becomes one
   always_comb begin
      clamp_w = (int'(cfg_w_ff) > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : cfg_w_ff;
      clamp_h = (int'(cfg_h_ff) > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : cfg_h_ff;
      priority if (cfg_t_ff == '0) begin
         clamp_t = TILE_W'(1);
      end else if (int'(cfg_t_ff) > MAX_TILE_SIZE) begin
         clamp_t = TILE_W'(MAX_TILE_SIZE);
      end else begin
         clamp_t = cfg_t_ff;
      end
   end

   // ceil division as (size + tile - 1) / tile
   always_comb begin
      if (cmd.latch_cfg) begin
         div_dividend = DIVD_W'(clamp_w) + DIVD_W'(clamp_t) - DIVD_W'(1);
      end else begin
         div_dividend = DIVD_W'(lat_h_ff) + DIVD_W'(lat_t_ff) - DIVD_W'(1);
      end
   end

   assign div_start = cmd.latch_cfg | cmd.div_next;

   stog_div #(
      .DIVD_W(DIVD_W),
      .DSOR_W(TILE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cmd.latch_cfg ? clamp_t : lat_t_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // one spiral step ahead of the cursor
   always_comb begin
      nx = cur_x_ff;
      ny = cur_y_ff;
      unique case (heading_ff)
         HEAD_RIGHT: nx = cur_x_ff + CUR_W'(1);
         HEAD_DOWN:  ny = cur_y_ff + CUR_W'(1);
         HEAD_LEFT:  nx = cur_x_ff - CUR_W'(1);
         HEAD_UP:    ny = cur_y_ff - CUR_W'(1);
         default: ;
      endcase
      leg_dec    = leg_left_ff - CUR_W'(1);
      head_n     = heading_ff;
      leg_len_n  = leg_len_ff;
      leg_left_n = leg_dec;
      if (leg_dec == '0) begin
         unique case (heading_ff)
            HEAD_RIGHT: head_n = HEAD_DOWN;
            HEAD_DOWN:  head_n = HEAD_LEFT;
            HEAD_LEFT:  head_n = HEAD_UP;
            HEAD_UP:    head_n = HEAD_RIGHT;
            default:    head_n = HEAD_RIGHT;
         endcase
         // the leg grows before each right and each left leg
         if (head_n == HEAD_RIGHT || head_n == HEAD_LEFT) begin
            leg_len_n = leg_len_ff + CUR_W'(1);
         end
         leg_left_n = leg_len_n;
      end
   end

   assign prod_x = PX_W'(cur_x_ff[DIM_W-1:0]) * PX_W'(lat_t_ff);
   assign prod_y = PX_W'(cur_y_ff[DIM_W-1:0]) * PX_W'(lat_t_ff);

   // the cursor tile lies inside the image, so the offset is below the size
   assign lx     = lat_w_ff - px_ff;
   assign ly     = lat_h_ff - py_ff;
   assign clip_w = (lx < DIM_W'(lat_t_ff)) ? lx[TILE_W-1:0] : lat_t_ff;
   assign clip_h = (ly < DIM_W'(lat_t_ff)) ? ly[TILE_W-1:0] : lat_t_ff;

   // spiral state
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         heading_ff   <= HEAD_RIGHT;
         leg_left_ff  <= CUR_W'(1);
         leg_len_ff   <= CUR_W'(1);
      end else begin
         if (cmd.init_spiral) begin
            remaining_ff <= REM_W'(across_ff) * REM_W'(down_ff);
            cur_x_ff     <= CUR_W'(across_ff >> 1);
            cur_y_ff     <= CUR_W'(down_ff >> 1);
            heading_ff   <= HEAD_RIGHT;
            leg_left_ff  <= CUR_W'(1);
            leg_len_ff   <= CUR_W'(1);
         end else if (cmd.step) begin
            cur_x_ff    <= nx;
            cur_y_ff    <= ny;
            heading_ff  <= head_n;
            leg_left_ff <= leg_left_n;
            leg_len_ff  <= leg_len_n;
         end
         if (cmd.load_out && remaining_ff != '0) begin
            remaining_ff <= remaining_ff - REM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_cfg) begin
         lat_w_ff <= clamp_w;
         lat_h_ff <= clamp_h;
         lat_t_ff <= clamp_t;
      end
      if (cmd.div_next) begin
         across_ff <= div_quot[CNT_W-1:0];
      end
      if (cmd.store_y) begin
         down_ff <= div_quot[CNT_W-1:0];
      end
      if (cmd.calc_pos) begin
         px_ff <= prod_x[DIM_W-1:0];
         py_ff <= prod_y[DIM_W-1:0];
      end
   end

   // result register, refilled in the cycle it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         if (remaining_ff == '0) begin
            out_tvalid_ff <= 1'b0;
            out_x_ff      <= '0;
            out_y_ff      <= '0;
            out_w_ff      <= '0;
            out_h_ff      <= '0;
            out_last_ff   <= 1'b0;
         end else begin
            out_tvalid_ff <= 1'b1;
            out_x_ff      <= px_ff;
            out_y_ff      <= py_ff;
            out_w_ff      <= clip_w;
            out_h_ff      <= clip_h;
            out_last_ff   <= (remaining_ff == REM_W'(1));
         end
      end
   end

   always_comb begin
      stat.div_done       = div_done;
      stat.remaining_zero = (remaining_ff == '0);
      stat.remaining_one  = (remaining_ff == REM_W'(1));
      stat.next_on_grid   = !nx[CUR_W-1] && !ny[CUR_W-1] &&
                            (nx[CUR_W-2:0] < (CUR_W-1)'(across_ff)) &&
                            (ny[CUR_W-2:0] < (CUR_W-1)'(down_ff));
      stat.out_full       = out_valid_ff & rsp_stall;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tile_valid    = out_tvalid_ff;
   assign rsp_tile_offset_x = out_x_ff;
   assign rsp_tile_offset_y = out_y_ff;
   assign rsp_tile_width    = out_w_ff;
   assign rsp_tile_height   = out_h_ff;
   assign rsp_tile_last     = out_last_ff;

endmodule

### tb/sv/spiral_tile_order_generator_top_test.sv
// self-checking testbench of the spiral tile order generator with its own spiral predictor
`timescale 1ns / 1ps
module spiral_tile_order_generator_top_test;
   import stog_pkg::*;

   localparam logic [IDX_W-1:0] CSR_SPARE = 2'd3;   // no register behind this index
   localparam int RANDOM_ITEMS  = 1950;
   localparam int HOLD_CYCLES   = 400;
   // longest quiet stretch: receiver hold plus a restart divide plus a long walk on a strip
   localparam int IDLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic              valid;
      logic [DIM_W-1:0]  off_x;
      logic [DIM_W-1:0]  off_y;
      logic [TILE_W-1:0] width;
      logic [TILE_W-1:0] height;
      logic              last;
   } tile_word_type;

   class spiral_order_tracker;
      logic [DIM_W-1:0]  image_w;
      logic [DIM_W-1:0]  image_h;
      logic [TILE_W-1:0] tile_sz;
      int span_w, span_h, span_t, grid_w, grid_h;
      longint tiles_left;
      int pos_x, pos_y, leg_left, leg_len;
      heading_type dir;
      tile_word_type expected_tiles[$];
      int mismatch_count;

      function new();
         image_w = RST_IMAGE_WIDTH;
         image_h = RST_IMAGE_HEIGHT;
         tile_sz = RST_TILE_SIZE;
         span_w = 0;
         span_h = 0;
         span_t = 0;
         grid_w = 0;
         grid_h = 0;
         tiles_left = 0;
         pos_x = 0;
         pos_y = 0;
         leg_left = 1;
         leg_len = 1;
         dir = HEAD_RIGHT;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH: image_w = data;
            CSR_IMAGE_HEIGHT: image_h = data;
            CSR_TILE_SIZE: tile_sz = data[TILE_W-1:0];
            default: ;
         endcase
      endfunction

      function void start_spiral();
         if (tile_sz == 0) span_t = 1;
         else if (tile_sz > MAX_TILE_SIZE_DEF) span_t = MAX_TILE_SIZE_DEF;
         else span_t = tile_sz;
         span_w = (image_w > MAX_IMAGE_DIM_DEF) ? MAX_IMAGE_DIM_DEF : image_w;
         span_h = (image_h > MAX_IMAGE_DIM_DEF) ? MAX_IMAGE_DIM_DEF : image_h;
         grid_w = (span_w + span_t - 1) / span_t;
         grid_h = (span_h + span_t - 1) / span_t;
         tiles_left = longint'(grid_w) * longint'(grid_h);
         pos_x = grid_w / 2;
         pos_y = grid_h / 2;
         dir = HEAD_RIGHT;
         leg_left = 1;
         leg_len = 1;
      endfunction

      function bit on_grid();
         return pos_x >= 0 && pos_y >= 0 && pos_x < grid_w && pos_y < grid_h;
      endfunction

      function void spiral_move();
         logic [1:0] nxt;
         case (dir)
            HEAD_RIGHT: pos_x++;
            HEAD_DOWN: pos_y++;
            HEAD_LEFT: pos_x--;
            default: pos_y--;
         endcase
         leg_left--;
         if (leg_left == 0) begin
            nxt = dir + 2'd1;
            dir = heading_type'(nxt);
            // leg grows before each right and each left leg
            if (dir == HEAD_RIGHT || dir == HEAD_LEFT) leg_len++;
            leg_left = leg_len;
         end
      endfunction

      function void note_request(logic restart);
         tile_word_type t;
         int px, py;
         if (restart) start_spiral();
         t.valid = 1'b0;
         t.off_x = '0;
         t.off_y = '0;
         t.width = '0;
         t.height = '0;
         t.last = 1'b0;
         if (tiles_left != 0) begin
            px = pos_x * span_t;
            py = pos_y * span_t;
            t.valid = 1'b1;
            t.off_x = px[DIM_W-1:0];
            t.off_y = py[DIM_W-1:0];
            t.width = TILE_W'((span_w - px < span_t) ? span_w - px : span_t);
            t.height = TILE_W'((span_h - py < span_t) ? span_h - py : span_t);
            tiles_left--;
            if (tiles_left == 0) begin
               t.last = 1'b1;
            end else begin
               do spiral_move(); while (!on_grid());
            end
         end
         expected_tiles.push_back(t);
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= 50) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_tile(tile_word_type got);
         tile_word_type exp_t;
         if (expected_tiles.size() == 0) begin
            report_mismatch($sformatf("word with none pending, x %0d y %0d",
                                      got.off_x, got.off_y));
            return;
         end
         exp_t = expected_tiles.pop_front();
         if (got.valid !== exp_t.valid)
            report_mismatch($sformatf("tile_valid %b, want %b", got.valid, exp_t.valid));
         if (got.off_x !== exp_t.off_x)
            report_mismatch($sformatf("offset_x %0d, want %0d", got.off_x, exp_t.off_x));
         if (got.off_y !== exp_t.off_y)
            report_mismatch($sformatf("offset_y %0d, want %0d", got.off_y, exp_t.off_y));
         if (got.width !== exp_t.width)
            report_mismatch($sformatf("width %0d, want %0d", got.width, exp_t.width));
         if (got.height !== exp_t.height)
            report_mismatch($sformatf("height %0d, want %0d", got.height, exp_t.height));
         if (got.last !== exp_t.last)
            report_mismatch($sformatf("tile_last %b, want %b", got.last, exp_t.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_restart = 1'b0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_tile_valid;
   logic [DIM_W-1:0] rsp_tile_offset_x;
   logic [DIM_W-1:0] rsp_tile_offset_y;
   logic [TILE_W-1:0] rsp_tile_width;
   logic [TILE_W-1:0] rsp_tile_height;
   logic rsp_tile_last;

   spiral_order_tracker tracker;
   bit hold_rsp = 1'b0;
   bit no_gaps = 1'b0;
   int idle_cycles = 0;
   int requests_sent = 0;

   spiral_tile_order_generator_top DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tile_valid    (rsp_tile_valid),
      .rsp_tile_offset_x (rsp_tile_offset_x),
      .rsp_tile_offset_y (rsp_tile_offset_y),
      .rsp_tile_width    (rsp_tile_width),
      .rsp_tile_height   (rsp_tile_height),
      .rsp_tile_last     (rsp_tile_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      tile_word_type got;
      if (!reset) begin
         if (csr_we) tracker.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) tracker.note_request(req_restart);
         if (rsp_valid && !rsp_stall) begin
            got.valid = rsp_tile_valid;
            got.off_x = rsp_tile_offset_x;
            got.off_y = rsp_tile_offset_y;
            got.width = rsp_tile_width;
            got.height = rsp_tile_height;
            got.last = rsp_tile_last;
            tracker.check_tile(got);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stall before each word, quiet stretches, one long hold on request
   initial begin : rsp_side
      int n;
      bit quiet;
      quiet = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 24) == 0) quiet = !quiet;
         n = hold_rsp ? HOLD_CYCLES : (quiet ? 0 : $urandom_range(0, 11));
         hold_rsp = 1'b0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic write_csr(input logic [IDX_W-1:0] idx, input int unsigned data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned t);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_TILE_SIZE, t);
   endtask

   task automatic send_request(input logic restart);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // drop the request and wait until every pending word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.expected_tiles.size() != 0);
      @(posedge clock);
   endtask

   task automatic random_geometry();
      int unsigned t, w, h, mode, swap;
      mode = $urandom_range(0, 11);
      if (mode <= 6) begin
         t = $urandom_range(1, 64);
         w = t * $urandom_range(1, 10) - $urandom_range(0, t - 1);
         h = t * $urandom_range(1, 10) - $urandom_range(0, t - 1);
      end else if (mode == 7) begin
         // one tile row or column, the walk skips most of each ring
         t = $urandom_range(1, 8);
         w = t * $urandom_range(8, 32);
         h = $urandom_range(1, t);
         if ($urandom_range(0, 1) == 1) begin
            swap = w;
            w = h;
            h = swap;
         end
      end else if (mode == 8) begin
         t = $urandom_range(300, 1024);
         w = $urandom_range(1, 16383);
         h = $urandom_range(1, 16383);
      end else if (mode == 9) begin
         t = $urandom_range(1025, 2047);   // saturates
         w = $urandom_range(1, 16383);
         h = $urandom_range(1, 16383);
      end else if (mode == 10) begin
         t = 0;
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 12);
      end else begin
         t = $urandom_range(1, 64);
         w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 200);
         h = (w == 0) ? $urandom_range(0, 200) : 0;
      end
      // bits above the tile register are dropped
      if ($urandom_range(0, 3) == 0) t = t | ($urandom_range(1, 7) << TILE_W);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, $urandom_range(0, 16383));
      set_geometry(w, h, t);
   endtask

   initial begin : req_side
      int n, phase;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no restart yet, so no tile
      send_request(1'b0);
      // reset geometry 640 x 480 with 32 pixel tiles
      send_request(1'b1);
      send_request(1'b0);
      wait_drained();
      // whole 3 x 2 grid, then one word past the last tile
      set_geometry(3, 2, 1);
      send_request(1'b1);
      repeat (6) send_request(1'b0);
      wait_drained();
      // empty grid
      set_geometry(0, 5, 4);
      send_request(1'b1);
      wait_drained();
      // zero tile size acts as one pixel
      set_geometry(2, 1, 0);
      send_request(1'b1);
      send_request(1'b0);
      wait_drained();
      // largest image, oversized tile
      set_geometry(16383, 16383, 2047);
      send_request(1'b1);
      send_request(1'b0);
      wait_drained();
      // new sizes stay unlatched while the running spiral goes on
      set_geometry(100, 70, 32);
      write_csr(CSR_SPARE, 16383);
      send_request(1'b0);
      send_request(1'b0);
      wait_drained();
      set_geometry(16383, 1, 1);
      send_request(1'b1);
      repeat (3) send_request(1'b0);
      wait_drained();
      set_geometry(1, 16383, 1024);
      send_request(1'b1);
      send_request(1'b0);
      wait_drained();

      requests_sent = 0;
      phase = 0;
      while (requests_sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 5) == 0);
         if (phase == 6 || phase == 40) begin
            // hold the result side so the block backs up and stalls requests
            set_geometry(1000, 1000, 64);
            hold_rsp = 1'b1;
            no_gaps = 1'b1;
            send_request(1'b1);
            repeat (30) send_request(1'b0);
         end else begin
            if ($urandom_range(0, 3) != 0) random_geometry();
            n = $urandom_range(1, 40);
            send_request($urandom_range(0, 9) != 0);
            repeat (n - 1) send_request($urandom_range(0, 19) == 0);
         end
         wait_drained();
         phase++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.expected_tiles.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/stog_pkg.sv
design/stog_div.sv
design/stog_ctrl.sv
design/stog_dpath.sv
design/spiral_tile_order_generator_top.sv
tb/sv/spiral_tile_order_generator_top_test.sv
